### src/uer_pkg.sv
package uer_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned DIST_W   = 27;
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned S_USER_W = 8;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned M_USER_W = 8;
    localparam logic [WORD_W-1:0] TIMEOUT_RESET = 32'd30000;

    typedef enum logic [2:0] {
        MODE_UNINIT     = 3'd0,
        MODE_READY      = 3'd1,
        MODE_TRIGGER    = 3'd2,
        MODE_WAIT_RISE  = 3'd3,
        MODE_WAIT_FALL  = 3'd4,
        MODE_DATA_READY = 3'd5,
        MODE_TIMEOUT    = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_INIT_HW      = 3'd1,
        ACT_SEND_TRIGGER = 3'd2,
        ACT_ARM_RISING   = 3'd3,
        ACT_ARM_FALLING  = 3'd4,
        ACT_STOP_TIMER   = 3'd5,
        ACT_STOP_RESET   = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        CMD_INIT     = 3'd0,
        CMD_START    = 3'd1,
        CMD_TRIG_DONE = 3'd2,
        CMD_EDGE     = 3'd3,
        CMD_OVERFLOW = 3'd4,
        CMD_READ     = 3'd5
    } cmd_t;

    typedef struct packed {
        mode_t              mode;
        action_t            action;
        logic               valid;
        logic [DIST_W-1:0]  distance;
    } result_t;

endpackage

### src/uer_recip_div.sv
module uer_recip_div #(
    parameter int unsigned DIVISOR = 58
) (
    input  logic [uer_pkg::WORD_W-1:0] dividend,
    output logic [uer_pkg::WORD_W-1:0] quotient
);
    import uer_pkg::*;

    // floor(n / d) = (n * ceil(2^(W+L) / d)) >> (W+L), L = ceil(log2 d)
    localparam int unsigned SHIFT_L = $clog2(DIVISOR);
    localparam int unsigned SHIFT   = WORD_W + SHIFT_L;
    localparam int unsigned PROD_W  = SHIFT + WORD_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [WORD_W:0]   recip;
    logic [PROD_W-1:0] product;

    assign recip    = RECIP_FULL[WORD_W:0];
    assign product  = {{(PROD_W-WORD_W){1'b0}}, dividend}
                    * {{(PROD_W-WORD_W-1){1'b0}}, recip};
    assign quotient = product[SHIFT +: WORD_W];

endmodule

### src/uer_ctrl.sv
module uer_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [uer_pkg::CMD_W-1:0]     cmd,
    input  logic [uer_pkg::WORD_W-1:0]    period,
    input  logic [uer_pkg::WORD_W-1:0]    timeout,
    input  logic [uer_pkg::WORD_W-1:0]    quotient,
    output uer_pkg::result_t              res
);
    import uer_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [WORD_W-1:0]  wait_reg, wait_next;
    logic [WORD_W-1:0]  dist_reg, dist_next;
    logic [WORD_W:0]    sum;
    logic [WORD_W-1:0]  sum_sat;
    action_t            act;
    logic               valid;
    logic [DIST_W-1:0]  reading;

    assign sum     = {1'b0, wait_reg} + {1'b0, period};
    assign sum_sat = sum[WORD_W] ? {WORD_W{1'b1}} : sum[WORD_W-1:0];

    always_comb begin
        mode_next = mode_reg;
        wait_next = wait_reg;
        dist_next = dist_reg;
        unique case (cmd_t'(cmd))
            CMD_INIT: begin
                if (mode_reg == MODE_UNINIT) begin
                    mode_next = MODE_READY;
                end
            end
            CMD_START: begin
                if (mode_reg == MODE_READY || mode_reg == MODE_TIMEOUT) begin
                    mode_next = MODE_TRIGGER;
                end
            end
            CMD_TRIG_DONE: begin
                if (mode_reg == MODE_TRIGGER) begin
                    wait_next = '0;
                    mode_next = MODE_WAIT_RISE;
                end
            end
            CMD_EDGE: begin
                if (mode_reg == MODE_WAIT_RISE) begin
                    mode_next = MODE_WAIT_FALL;
                end else if (mode_reg == MODE_WAIT_FALL) begin
                    dist_next = quotient;
                    mode_next = MODE_DATA_READY;
                end
            end
            CMD_OVERFLOW: begin
                if (mode_reg == MODE_WAIT_RISE || mode_reg == MODE_WAIT_FALL) begin
                    wait_next = sum_sat;
                    if (sum_sat >= timeout) begin
                        mode_next = MODE_TIMEOUT;
                    end
                end
            end
            CMD_READ: begin
                if (mode_reg == MODE_DATA_READY) begin
                    mode_next = MODE_READY;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        act     = ACT_NONE;
        valid   = 1'b0;
        reading = '0;
        unique case (cmd_t'(cmd))
            CMD_INIT: begin
                if (mode_reg == MODE_UNINIT) begin
                    act = ACT_INIT_HW;
                end
            end
            CMD_START: begin
                if (mode_reg == MODE_READY || mode_reg == MODE_TIMEOUT) begin
                    act = ACT_SEND_TRIGGER;
                end
            end
            CMD_TRIG_DONE: begin
                if (mode_reg == MODE_TRIGGER) begin
                    act = ACT_ARM_RISING;
                end
            end
            CMD_EDGE: begin
                if (mode_reg == MODE_WAIT_RISE) begin
                    act = ACT_ARM_FALLING;
                end else if (mode_reg == MODE_WAIT_FALL) begin
                    act = ACT_STOP_TIMER;
                end
            end
            CMD_OVERFLOW: begin
                if ((mode_reg == MODE_WAIT_RISE || mode_reg == MODE_WAIT_FALL)
                    && sum_sat >= timeout) begin
                    act = ACT_STOP_RESET;
                end
            end
            CMD_READ: begin
                if (mode_reg == MODE_DATA_READY) begin
                    valid   = 1'b1;
                    reading = dist_reg[DIST_W-1:0];
                end
            end
            default: ;
        endcase
        res.mode     = mode_next;
        res.action   = act;
        res.valid    = valid;
        res.distance = reading;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_UNINIT;
            wait_reg <= '0;
            dist_reg <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            wait_reg <= wait_next;
            dist_reg <= dist_next;
        end
    end

endmodule

### src/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranging sequencer.
// Input stream: one event word per item; s_tuser carries the command
// (initialize, start, trigger done, edge captured, timer overflow, read),
// s_tdata the captured tick count and the overflow period.
// Output stream: one result word per event with the mode after the event,
// the hardware action to take, and on a read in data-ready the distance in
// centimetres (echo ticks / TICKS_PER_CM, floored) with m_tuser[0] set.
// Config channel: cfg_data writes the timeout register (wait ticks allowed
// before timeout); always ready, write only while the stream is idle.
// Each event passes through the input register, then its result through the output
// register to m_*. Throughput: one event per cycle while m_tready is high, set by the
// single step from the input register through the mode logic and reciprocal
// multiplier to the output register.
// Reset: mode uninitialized, elapsed ticks and stored distance cleared, timeout 30000.
// When m_tready is low the output word holds, the input register still
// fills, and s_tready drops once both are occupied.
module ultrasonic_echo_ranger_core #(
    parameter int unsigned TICKS_PER_CM = 58
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uer_pkg::WORD_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [uer_pkg::S_DATA_W-1:0]    s_tdata,  // capture_value, overflow_period
    input  logic [uer_pkg::S_USER_W-1:0]    s_tuser,  // command, zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uer_pkg::M_DATA_W-1:0]    m_tdata,  // mode, action, range_cm, pad
    output logic [uer_pkg::M_USER_W-1:0]    m_tuser   // measurement_valid, zero pad
);
    import uer_pkg::*;

    logic [WORD_W-1:0]  timeout_reg;
    logic               in_valid_reg;
    logic [CMD_W-1:0]   in_cmd_reg;
    logic [WORD_W-1:0]  in_cap_reg;
    logic [WORD_W-1:0]  in_period_reg;
    logic               out_valid_reg;
    result_t            out_res_reg;
    result_t            res;
    logic [WORD_W-1:0]  quotient;
    logic               advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg    <= s_tuser[CMD_W-1:0];
            in_cap_reg    <= s_tdata[WORD_W-1:0];
            in_period_reg <= s_tdata[2*WORD_W-1:WORD_W];
        end
    end

    uer_recip_div #(
        .DIVISOR (TICKS_PER_CM)
    ) u_div (
        .dividend (in_cap_reg),
        .quotient (quotient)
    );

    uer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .cmd      (in_cmd_reg),
        .period   (in_period_reg),
        .timeout  (timeout_reg),
        .quotient (quotient),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-DIST_W-6){1'b0}}, out_res_reg.distance,
                       out_res_reg.action, out_res_reg.mode};
    assign m_tuser  = {{(M_USER_W-1){1'b0}}, out_res_reg.valid};

endmodule

### dv/tb_ultrasonic_echo_ranger_core.sv
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger_core;
    import uer_pkg::*;

    localparam int unsigned CM_TICKS   = 58;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [WORD_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // capture_value, overflow_period
    logic [S_USER_W-1:0]   s_tuser;   // command, zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;   // mode, action, range_cm, pad
    logic [M_USER_W-1:0]   m_tuser;   // measurement_valid, zero pad

    // predicted block state
    mode_t       ranger_mode;
    logic [31:0] echo_ticks;
    logic [31:0] elapsed_ticks;
    logic [31:0] timeout_limit;

    result_t     pending_readings[$];
    bit          steady = 1'b0;
    int          events_sent = 0;
    int          words_checked = 0;
    int          distance_reads = 0;
    int          timeouts_seen = 0;
    int          timeout_writes = 0;
    int          errors = 0;
    int          idle_cycles = 0;

    ultrasonic_echo_ranger_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic result_t next_ranging_result(input logic [2:0] cmd,
                                                    input logic [31:0] cap,
                                                    input logic [31:0] period);
        result_t     r;
        logic [32:0] sum;
        r.action   = ACT_NONE;
        r.valid    = 1'b0;
        r.distance = '0;
        case (cmd)
            CMD_INIT: begin
                if (ranger_mode == MODE_UNINIT) begin
                    r.action    = ACT_INIT_HW;
                    ranger_mode = MODE_READY;
                end
            end
            CMD_START: begin
                if (ranger_mode == MODE_READY || ranger_mode == MODE_TIMEOUT) begin
                    r.action    = ACT_SEND_TRIGGER;
                    ranger_mode = MODE_TRIGGER;
                end
            end
            CMD_TRIG_DONE: begin
                if (ranger_mode == MODE_TRIGGER) begin
                    elapsed_ticks = '0;
                    r.action      = ACT_ARM_RISING;
                    ranger_mode   = MODE_WAIT_RISE;
                end
            end
            CMD_EDGE: begin
                if (ranger_mode == MODE_WAIT_RISE) begin
                    r.action    = ACT_ARM_FALLING;
                    ranger_mode = MODE_WAIT_FALL;
                end else if (ranger_mode == MODE_WAIT_FALL) begin
                    echo_ticks  = cap;
                    r.action    = ACT_STOP_TIMER;
                    ranger_mode = MODE_DATA_READY;
                end
            end
            CMD_OVERFLOW: begin
                if (ranger_mode == MODE_WAIT_RISE || ranger_mode == MODE_WAIT_FALL) begin
                    sum = {1'b0, elapsed_ticks} + {1'b0, period};
                    elapsed_ticks = sum[32] ? ALL_ONES : sum[31:0];
                    if (elapsed_ticks >= timeout_limit) begin
                        r.action    = ACT_STOP_RESET;
                        ranger_mode = MODE_TIMEOUT;
                        timeouts_seen++;
                    end
                end
            end
            CMD_READ: begin
                if (ranger_mode == MODE_DATA_READY) begin
                    r.valid    = 1'b1;
                    r.distance = DIST_W'(echo_ticks / CM_TICKS);
                    ranger_mode = MODE_READY;
                    distance_reads++;
                end
            end
            default: ;
        endcase
        r.mode = ranger_mode;
        return r;
    endfunction

    // receiver back-pressure
    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 27);

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.mode     = mode_t'(m_tdata[2:0]);
            got.action   = action_t'(m_tdata[5:3]);
            got.distance = m_tdata[6 +: DIST_W];
            got.valid    = m_tuser[0];
            if (pending_readings.size() == 0) begin
                errors++;
                $display("%0t: unexpected word mode=%0d action=%0d valid=%0b range=%0d",
                         $time, got.mode, got.action, got.valid, got.distance);
            end else begin
                want = pending_readings.pop_front();
                words_checked++;
                if (got.mode !== want.mode) begin
                    errors++;
                    $display("%0t: mode expected %0d actual %0d", $time, want.mode, got.mode);
                end
                if (got.action !== want.action) begin
                    errors++;
                    $display("%0t: action expected %0d actual %0d",
                             $time, want.action, got.action);
                end
                if (got.valid !== want.valid) begin
                    errors++;
                    $display("%0t: measurement_valid expected %0b actual %0b",
                             $time, want.valid, got.valid);
                end
                if (got.distance !== want.distance) begin
                    errors++;
                    $display("%0t: range_cm expected %0d actual %0d",
                             $time, want.distance, got.distance);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_event(input logic [2:0] cmd, input logic [31:0] cap,
                              input logic [31:0] period);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 27)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {{(S_USER_W-3){1'b0}}, cmd};
        s_tdata  <= {period, cap};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_readings.push_back(next_ranging_result(cmd, cap, period));
        events_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_timeout(input logic [31:0] ticks);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        timeout_limit = ticks;
        timeout_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_sequencing;
        send_event(CMD_READ, ALL_ONES, ALL_ONES);
        send_event(CMD_START, 32'd0, 32'd0);
        send_event(CMD_INIT, 32'd0, 32'd0);
        send_event(CMD_INIT, ALL_ONES, ALL_ONES);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_EDGE, 32'd1234, 32'd0);
        send_event(CMD_OVERFLOW, 32'd0, 32'd500);
        send_event(CMD_READ, 32'd0, 32'd0);
        send_event(CMD_START, 32'd0, 32'd0);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_EDGE, ALL_ONES, 32'd0);
        send_event(CMD_OVERFLOW, 32'd0, 32'd29999);
        send_event(CMD_EDGE, ALL_ONES, 32'd0);
        send_event(CMD_READ, 32'd0, ALL_ONES);
        send_event(CMD_READ, 32'd0, 32'd0);
        send_event(CMD_SPARE_LO, ALL_ONES, ALL_ONES);
        send_event(CMD_SPARE_HI, ALL_ONES, ALL_ONES);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_EDGE, 32'd77, 32'd0);
        send_event(CMD_OVERFLOW, 32'd0, ALL_ONES);
        send_event(CMD_START, 32'd0, 32'd0);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_EDGE, 32'd0, 32'd0);
        send_event(CMD_EDGE, 32'd57, 32'd0);
        send_event(CMD_READ, 32'd0, 32'd0);
        drain_results();
    endtask

    task automatic test_timeout_edges;
        write_timeout(32'd0);
        send_event(CMD_START, 32'd0, 32'd0);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_OVERFLOW, 32'd0, 32'd0);
        write_timeout(ALL_ONES);
        send_event(CMD_START, 32'd0, 32'd0);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_EDGE, 32'd0, 32'd0);
        send_event(CMD_OVERFLOW, 32'd0, 32'h8000_0000);
        send_event(CMD_OVERFLOW, 32'd0, 32'h8000_0000);
        write_timeout(32'd58);
        send_event(CMD_START, 32'd0, 32'd0);
        send_event(CMD_TRIG_DONE, 32'd0, 32'd0);
        send_event(CMD_OVERFLOW, 32'd0, 32'd57);
        send_event(CMD_OVERFLOW, 32'd0, 32'd1);
        drain_results();
    endtask

    function automatic logic [31:0] pick_period;
        case ($urandom_range(9))
            0: return 32'd0;
            1: return ALL_ONES;
            2, 3: return $urandom;
            default: return $urandom_range(0, (timeout_limit >> 3) + 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_capture;
        case ($urandom_range(7))
            0: return 32'd0;
            1: return ALL_ONES;
            2: return $urandom_range(0, 200);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_measurement;
        int n;
        if ($urandom_range(19) == 0)
            send_event(CMD_INIT, $urandom, $urandom);
        send_event(CMD_START, $urandom, $urandom);
        send_event(CMD_TRIG_DONE, $urandom, $urandom);
        n = $urandom_range(0, 3);
        repeat (n) send_event(CMD_OVERFLOW, $urandom, pick_period());
        send_event(CMD_EDGE, $urandom, $urandom);
        n = $urandom_range(0, 3);
        repeat (n) send_event(CMD_OVERFLOW, $urandom, pick_period());
        send_event(CMD_EDGE, pick_capture(), $urandom);
        if ($urandom_range(9) != 0)
            send_event(CMD_READ, $urandom, $urandom);
    endtask

    task automatic test_random_phase(input logic [31:0] ticks, input int count);
        int goal;
        write_timeout(ticks);
        goal = events_sent + count;
        while (events_sent < goal) begin
            if ($urandom_range(99) < 15)
                send_event(3'($urandom_range(7)), $urandom, $urandom);
            else
                run_measurement();
        end
        drain_results();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        ranger_mode   = MODE_UNINIT;
        echo_ticks    = '0;
        elapsed_ticks = '0;
        timeout_limit = TIMEOUT_RESET;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_sequencing();
        test_timeout_edges();
        steady = 1'b1;
        test_random_phase(TIMEOUT_RESET, 270);
        steady = 1'b0;
        test_random_phase(32'd0, 270);
        test_random_phase(32'd1, 270);
        test_random_phase(ALL_ONES, 270);
        test_random_phase($urandom_range(100, 100000), 270);
        test_random_phase($urandom, 270);

        drain_results();
        repeat (4) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_readings.size());
        end
        $display("Covered %0d events and %0d result words over %0d timeout settings,",
                 events_sent, words_checked, timeout_writes);
        $display("with %0d distance reads and %0d timeouts.", distance_reads, timeouts_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
